/* sv/cbq_pkg.sv */
// Package with shared constants and types of the cruise button qualifier.
`timescale 1ns / 1ps

package cbq_pkg;

    localparam int NUM_BTN  = 3;
    localparam int GRACE_W  = 16;
    localparam int DEB_W    = 8;
    localparam int SPEED_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [GRACE_W-1:0] GRACE_MAX   = '1;
    localparam logic [DEB_W-1:0]   DEB_MAX     = '1;
    localparam logic [GRACE_W-1:0] GRACE_RESET = 16'd500;
    localparam logic [DEB_W-1:0]   DEB_RESET   = 8'd50;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd50;
    localparam logic [SPEED_W-1:0] SPEED_MIN   = 8'd30;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 8'd150;
    localparam logic [SPEED_W-1:0] SPEED_STEP  = 8'd5;

    // button positions within the level vector
    localparam int BTN_ONOFF = 0;
    localparam int BTN_DOWN  = 1;
    localparam int BTN_UP    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NO_PEDAL     = 3'd0,
        CFG_DEBUG        = 3'd1,
        CFG_CLUTCH_GRACE = 3'd2,
        CFG_BRAKE_GRACE  = 3'd3,
        CFG_DEBOUNCE     = 3'd4,
        CFG_DEF_SPEED    = 3'd5,
        CFG_DEF_LANE     = 3'd6
    } t_cfg_idx;

endpackage

/* sv/cbq_tick_if.sv */
// Input channel interface: one tick item with pedal and button levels.
`timescale 1ns / 1ps

interface cbq_tick_if;
    logic valid;
    logic ready;
    logic clutch_level;
    logic brake_level;
    logic onoff_level;
    logic down_level;
    logic up_level;

    modport source (output valid, clutch_level, brake_level, onoff_level, down_level,
                    up_level, input ready);
    modport sink   (input valid, clutch_level, brake_level, onoff_level, down_level,
                    up_level, output ready);
endinterface

/* sv/cbq_result_if.sv */
// Output channel interface: one qualified result item per tick.
`timescale 1ns / 1ps

interface cbq_result_if import cbq_pkg::*;;
    logic               valid;
    logic               ready;
    logic               clutch_pressed;
    logic               brake_pressed;
    logic               engaged;
    logic [SPEED_W-1:0] set_speed;
    logic               lane_keep;

    modport source (output valid, clutch_pressed, brake_pressed, engaged, set_speed,
                    lane_keep, input ready);
    modport sink   (input valid, clutch_pressed, brake_pressed, engaged, set_speed,
                    lane_keep, output ready);
endinterface

/* sv/cruise_button_qualifier.sv */
// An accepted tick item passes through the input register and then the result register.
// Throughput: one item per cycle; the result register drains while the next item waits
// in the input register, so a stalled output only backs up after both are full.
// Reset (synchronous, active low): config registers to their defaults, pedal release
// counts saturated, buttons released and disarmed, system off, speed unset.
`timescale 1ns / 1ps

module cruise_button_qualifier import cbq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    cbq_tick_if.sink              i_tick,
    cbq_result_if.source          o_result
);

    // configuration
    logic               r_no_pedal;
    logic               r_debug;
    logic [GRACE_W-1:0] r_clutch_grace;
    logic [GRACE_W-1:0] r_brake_grace;
    logic [DEB_W-1:0]   r_debounce;
    logic [SPEED_W-1:0] r_def_speed;
    logic               r_def_lane;

    // item state
    logic [GRACE_W-1:0] r_clutch_cnt, n_clutch_cnt;
    logic [GRACE_W-1:0] r_brake_cnt, n_brake_cnt;
    logic [NUM_BTN-1:0] r_prev_lvl;
    logic [DEB_W-1:0]   r_stable [NUM_BTN];
    logic [DEB_W-1:0]   n_stable [NUM_BTN];
    logic [NUM_BTN-1:0] r_armed, n_armed;
    logic               r_on, n_on;
    logic               r_lane, n_lane;
    logic [SPEED_W-1:0] r_held, n_held;
    logic               r_spd_valid, n_spd_valid;

    // input and result stages
    logic               r_in_valid;
    logic               r_in_clutch, r_in_brake;
    logic [NUM_BTN-1:0] r_in_btn;
    logic               r_out_valid;
    logic               r_out_cp, r_out_bp, r_out_on, r_out_lane;
    logic [SPEED_W-1:0] r_out_speed;

    logic               w_adv;
    logic               w_cp, w_bp;
    logic [NUM_BTN-1:0] w_change, w_fire;
    logic [SPEED_W-1:0] w_spd_dn, w_spd_up, w_spd_out;

    assign w_adv        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready = !r_in_valid || w_adv;

    // pedal stretch
    always_comb begin
        n_clutch_cnt = r_clutch_cnt;
        n_brake_cnt  = r_brake_cnt;
        w_cp = 1'b0;
        w_bp = 1'b0;
        if (!r_no_pedal) begin
            if (r_in_clutch) begin
                n_clutch_cnt = '0;
            end else if (r_clutch_cnt != GRACE_MAX) begin
                n_clutch_cnt = r_clutch_cnt + 1'b1;
            end
            if (r_in_brake) begin
                n_brake_cnt = '0;
            end else if (r_brake_cnt != GRACE_MAX) begin
                n_brake_cnt = r_brake_cnt + 1'b1;
            end
            w_cp = r_in_clutch || (n_clutch_cnt < r_clutch_grace);
            w_bp = r_in_brake || (n_brake_cnt < r_brake_grace);
        end
    end

    // debounce: change restarts and arms, low + armed + settled fires once
    always_comb begin
        for (int i = 0; i < NUM_BTN; i++) begin
            w_change[i] = r_in_btn[i] != r_prev_lvl[i];
            if (w_change[i]) begin
                n_stable[i] = '0;
            end else if (r_stable[i] != DEB_MAX) begin
                n_stable[i] = r_stable[i] + 1'b1;
            end else begin
                n_stable[i] = r_stable[i];
            end
            w_fire[i]  = !r_in_btn[i] && (r_armed[i] || w_change[i]) &&
                         (n_stable[i] >= r_debounce);
            n_armed[i] = (r_armed[i] || w_change[i]) && !w_fire[i];
        end
    end

    // on/off, then down, then up
    always_comb begin
        n_on        = r_on;
        n_lane      = r_lane;
        n_held      = r_held;
        n_spd_valid = r_spd_valid;
        if (w_fire[BTN_ONOFF]) begin
            if (r_on) begin
                n_on = 1'b0;
            end else if (!r_debug) begin
                n_on   = 1'b1;
                n_lane = r_def_lane;
            end
        end
        w_spd_dn = r_spd_valid ? r_held : r_def_speed;
        if (w_fire[BTN_DOWN] && !r_debug && (w_spd_dn > SPEED_MIN)) begin
            n_held      = w_spd_dn - SPEED_STEP;
            n_spd_valid = 1'b1;
        end
        w_spd_up = n_spd_valid ? n_held : r_def_speed;
        if (w_fire[BTN_UP] && !r_debug && (w_spd_up < SPEED_MAX)) begin
            n_held      = w_spd_up + SPEED_STEP;
            n_spd_valid = 1'b1;
        end
        w_spd_out = n_spd_valid ? n_held : r_def_speed;
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_no_pedal     <= 1'b0;
            r_debug        <= 1'b0;
            r_clutch_grace <= GRACE_RESET;
            r_brake_grace  <= GRACE_RESET;
            r_debounce     <= DEB_RESET;
            r_def_speed    <= SPEED_RESET;
            r_def_lane     <= 1'b1;
            r_clutch_cnt   <= GRACE_MAX;
            r_brake_cnt    <= GRACE_MAX;
            r_prev_lvl     <= '1;
            r_armed        <= '0;
            for (int i = 0; i < NUM_BTN; i++) begin
                r_stable[i] <= '0;
            end
            r_on           <= 1'b0;
            r_lane         <= 1'b0;
            r_held         <= '0;
            r_spd_valid    <= 1'b0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_NO_PEDAL:     r_no_pedal     <= i_cfg_data[0];
                    CFG_DEBUG:        r_debug        <= i_cfg_data[0];
                    CFG_CLUTCH_GRACE: r_clutch_grace <= i_cfg_data[GRACE_W-1:0];
                    CFG_BRAKE_GRACE:  r_brake_grace  <= i_cfg_data[GRACE_W-1:0];
                    CFG_DEBOUNCE:     r_debounce     <= i_cfg_data[DEB_W-1:0];
                    CFG_DEF_SPEED:    r_def_speed    <= i_cfg_data[SPEED_W-1:0];
                    CFG_DEF_LANE:     r_def_lane     <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (w_adv) begin
                r_clutch_cnt <= n_clutch_cnt;
                r_brake_cnt  <= n_brake_cnt;
                r_prev_lvl   <= r_in_btn;
                r_armed      <= n_armed;
                r_stable     <= n_stable;
                r_on         <= n_on;
                r_lane       <= n_lane;
                r_held       <= n_held;
                r_spd_valid  <= n_spd_valid;
            end
            if (i_tick.valid && i_tick.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in_clutch         <= i_tick.clutch_level;
            r_in_brake          <= i_tick.brake_level;
            r_in_btn[BTN_ONOFF] <= i_tick.onoff_level;
            r_in_btn[BTN_DOWN]  <= i_tick.down_level;
            r_in_btn[BTN_UP]    <= i_tick.up_level;
        end
        if (w_adv) begin
            r_out_cp    <= w_cp;
            r_out_bp    <= w_bp;
            r_out_on    <= n_on;
            r_out_speed <= w_spd_out;
            r_out_lane  <= n_lane;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.clutch_pressed = r_out_cp;
    assign o_result.brake_pressed  = r_out_bp;
    assign o_result.engaged        = r_out_on;
    assign o_result.set_speed      = r_out_speed;
    assign o_result.lane_keep      = r_out_lane;

`ifndef NO_ASSERTIONS
    // debug mode never lets the system turn on
    a_debug_blocks_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_debug && !r_on) |=> !r_on)
        else $error("turned on in debug mode");

    // no-pedal mode freezes both release counts
    a_no_pedal_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_no_pedal) |=> ($stable(r_clutch_cnt) && $stable(r_brake_cnt)))
        else $error("release count moved in no-pedal mode");

    // a taken result with nothing behind it empties the result stage
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_result.ready && !w_adv) |=> !r_out_valid)
        else $error("result stage kept a delivered item");

    // a button fires at most once per press: a fire leaves it disarmed
    a_fire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (w_fire != '0)) |=> ((r_armed & $past(w_fire)) == '0))
        else $error("button still armed after firing");
`endif

endmodule

/* dv/cruise_button_qualifier_tb.sv */
// Testbench for the cruise button qualifier: tick stimulus, result prediction and checking.
`timescale 1ns / 1ps

module cruise_button_qualifier_tb;
    import cbq_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int NUM_PHASES  = 7;
    localparam int MAX_IDLE    = 18;
    localparam int PEDAL_CLUTCH = 0;
    localparam int PEDAL_BRAKE  = 1;

    typedef struct packed {
        logic clutch;
        logic brake;
        logic onoff;
        logic down;
        logic up;
    } t_tick;

    typedef struct packed {
        logic               clutch_pressed;
        logic               brake_pressed;
        logic               engaged;
        logic [SPEED_W-1:0] set_speed;
        logic               lane_keep;
    } t_qual;

    // Tracks pedal, debounce and cruise state per tick; holds expected results in order.
    class cruise_qual_scoreboard;
        logic               no_pedal;
        logic               debug_on;
        logic               default_lane;
        logic [GRACE_W-1:0] grace [2];
        logic [DEB_W-1:0]   debounce;
        logic [SPEED_W-1:0] default_speed;

        logic [GRACE_W-1:0] release_cnt [2];
        logic [NUM_BTN-1:0] prev_lv;
        logic [NUM_BTN-1:0] armed;
        logic [DEB_W-1:0]   stable_cnt [NUM_BTN];
        logic               on_flag;
        logic               lane_flag;
        logic               speed_set;
        logic [SPEED_W-1:0] held_speed;

        t_qual expected_outputs [$];
        int    errors;
        int    compared;
        int    turn_ons;
        int    speed_steps;

        function new();
            no_pedal = 1'b0;
            debug_on = 1'b0;
            default_lane = 1'b1;
            grace[PEDAL_CLUTCH] = GRACE_RESET;
            grace[PEDAL_BRAKE] = GRACE_RESET;
            debounce = DEB_RESET;
            default_speed = SPEED_RESET;
            release_cnt[PEDAL_CLUTCH] = GRACE_MAX;
            release_cnt[PEDAL_BRAKE] = GRACE_MAX;
            prev_lv = '1;
            armed = '0;
            foreach (stable_cnt[b]) stable_cnt[b] = '0;
            on_flag = 1'b0;
            lane_flag = 1'b0;
            speed_set = 1'b0;
            held_speed = '0;
            errors = 0;
            compared = 0;
            turn_ons = 0;
            speed_steps = 0;
        endfunction

        function void apply_cfg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_NO_PEDAL:     no_pedal = v[0];
                CFG_DEBUG:        debug_on = v[0];
                CFG_CLUTCH_GRACE: grace[PEDAL_CLUTCH] = v[GRACE_W-1:0];
                CFG_BRAKE_GRACE:  grace[PEDAL_BRAKE] = v[GRACE_W-1:0];
                CFG_DEBOUNCE:     debounce = v[DEB_W-1:0];
                CFG_DEF_SPEED:    default_speed = v[SPEED_W-1:0];
                CFG_DEF_LANE:     default_lane = v[0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        function logic pedal_step(int p, logic lvl);
            if (lvl)
                release_cnt[p] = '0;
            else if (release_cnt[p] != GRACE_MAX)
                release_cnt[p] = release_cnt[p] + 1'b1;
            return lvl || (release_cnt[p] < grace[p]);
        endfunction

        // change restarts the count and arms; fires once when held low long enough
        function logic button_fires(int b, logic lvl);
            if (lvl != prev_lv[b]) begin
                stable_cnt[b] = '0;
                armed[b] = 1'b1;
            end else if (stable_cnt[b] != DEB_MAX) begin
                stable_cnt[b] = stable_cnt[b] + 1'b1;
            end
            prev_lv[b] = lvl;
            if (!lvl && armed[b] && stable_cnt[b] >= debounce) begin
                armed[b] = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic [SPEED_W-1:0] speed_now();
            return speed_set ? held_speed : default_speed;
        endfunction

        function t_qual advance_tick(t_tick t);
            t_qual r;
            logic [SPEED_W-1:0] spd;
            r = '0;
            if (!no_pedal) begin
                r.clutch_pressed = pedal_step(PEDAL_CLUTCH, t.clutch);
                r.brake_pressed = pedal_step(PEDAL_BRAKE, t.brake);
            end
            if (button_fires(BTN_ONOFF, t.onoff)) begin
                if (on_flag) begin
                    on_flag = 1'b0;
                end else if (!debug_on) begin
                    on_flag = 1'b1;
                    lane_flag = default_lane;
                    turn_ons++;
                end
            end
            if (button_fires(BTN_DOWN, t.down)) begin
                spd = speed_now();
                if (!debug_on && spd > SPEED_MIN) begin
                    held_speed = spd - SPEED_STEP;
                    speed_set = 1'b1;
                    speed_steps++;
                end
            end
            if (button_fires(BTN_UP, t.up)) begin
                spd = speed_now();
                if (!debug_on && spd < SPEED_MAX) begin
                    held_speed = spd + SPEED_STEP;
                    speed_set = 1'b1;
                    speed_steps++;
                end
            end
            r.engaged = on_flag;
            r.set_speed = speed_now();
            r.lane_keep = lane_flag;
            return r;
        endfunction

        function void note_tick(t_tick t);
            expected_outputs.push_back(advance_tick(t));
        endfunction

        function void check_result(t_qual got);
            t_qual want;
            if (expected_outputs.size() == 0) begin
                $error("result item arrived with nothing expected");
                errors++;
                return;
            end
            want = expected_outputs.pop_front();
            compared++;
            if (got.clutch_pressed !== want.clutch_pressed) begin
                $error("clutch_pressed: expected %0d, got %0d",
                       want.clutch_pressed, got.clutch_pressed);
                errors++;
            end
            if (got.brake_pressed !== want.brake_pressed) begin
                $error("brake_pressed: expected %0d, got %0d",
                       want.brake_pressed, got.brake_pressed);
                errors++;
            end
            if (got.engaged !== want.engaged) begin
                $error("engaged: expected %0d, got %0d", want.engaged, got.engaged);
                errors++;
            end
            if (got.set_speed !== want.set_speed) begin
                $error("set_speed: expected %0d, got %0d", want.set_speed, got.set_speed);
                errors++;
            end
            if (got.lane_keep !== want.lane_keep) begin
                $error("lane_keep: expected %0d, got %0d", want.lane_keep, got.lane_keep);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cbq_tick_if   tick_ch ();
    cbq_result_if result_ch ();

    cruise_qual_scoreboard sb;
    logic [CFG_DATA_W-1:0] cfg_vals [CFG_DEF_LANE+1];
    int          phase_items [NUM_PHASES] = '{150, 150, 150, 200, 150, 150, 150};
    int          ticks_sent;
    int          settings_run;
    int unsigned idle_cycles;
    bit          tx_burst;
    bit          rx_burst;

    cruise_button_qualifier DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_tick     (tick_ch),
        .o_result   (result_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // accepted items on both channels, plus the stall watchdog
    always @(posedge i_clk) begin : monitor
        t_qual seen;
        logic  moved;
        moved = 1'b0;
        if (i_rst_n && tick_ch.valid && tick_ch.ready) begin
            sb.note_tick({tick_ch.clutch_level, tick_ch.brake_level, tick_ch.onoff_level,
                          tick_ch.down_level, tick_ch.up_level});
            moved = 1'b1;
        end
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            seen.clutch_pressed = result_ch.clutch_pressed;
            seen.brake_pressed = result_ch.brake_pressed;
            seen.engaged = result_ch.engaged;
            seen.set_speed = result_ch.set_speed;
            seen.lane_keep = result_ch.lane_keep;
            sb.check_result(seen);
            moved = 1'b1;
        end
        if (moved || !i_rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $error("no item moved for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, with bursts of constant ready
    initial begin
        result_ch.ready <= 1'b0;
        rx_burst = 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin : take_result
            int stall;
            stall = rx_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            if (stall != 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge i_clk); while (result_ch.valid !== 1'b1);
        end
    end

    task automatic send_tick(input t_tick t);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        if (gap != 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.clutch_level <= t.clutch;
        tick_ch.brake_level <= t.brake;
        tick_ch.onoff_level <= t.onoff;
        tick_ch.down_level <= t.down;
        tick_ch.up_level <= t.up;
        do @(posedge i_clk); while (tick_ch.ready !== 1'b1);
        ticks_sent++;
    endtask

    task automatic send_levels(input logic c, input logic b, input logic on,
                               input logic dn, input logic up);
        send_tick({c, b, on, dn, up});
    endtask

    // wait until every expected result is back, then let the pipeline settle;
    // first wait on the clock so the last accepted item is already noted
    task automatic drain();
        tick_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves the write enable high; caller lowers it after the last write
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.apply_cfg(idx, v);
    endtask

    function automatic void pick(int np, int dbg, int cg, int bg, int deb, int spd, int lane);
        cfg_vals[CFG_NO_PEDAL] = CFG_DATA_W'(np);
        cfg_vals[CFG_DEBUG] = CFG_DATA_W'(dbg);
        cfg_vals[CFG_CLUTCH_GRACE] = CFG_DATA_W'(cg);
        cfg_vals[CFG_BRAKE_GRACE] = CFG_DATA_W'(bg);
        cfg_vals[CFG_DEBOUNCE] = CFG_DATA_W'(deb);
        cfg_vals[CFG_DEF_SPEED] = CFG_DATA_W'(spd);
        cfg_vals[CFG_DEF_LANE] = CFG_DATA_W'(lane);
    endfunction

    task automatic set_phase_regs(input int p);
        case (p)
            0: pick(0, 0, 3, 7, 2, 50, 1);
            1: pick(1, 0, 10, 0, 0, 150, 0);
            2: pick(0, 1, 0, 65535, 4, 30, 1);
            3: pick(0, 0, 65535, 0, 255, 255, 0);
            4: pick(1, 1, 1, 1, 1, 0, 1);
            5: pick(0, 0, 20, 15, 5, 100, 0);
            default: pick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 30),
                          $urandom_range(0, 30), $urandom_range(0, 8),
                          $urandom_range(30, 150), $urandom_range(0, 1));
        endcase
        for (int r = 0; r <= CFG_DEF_LANE; r++)
            cfg_write(t_cfg_idx'(r), cfg_vals[r]);
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    // mostly clean presses, about half held past the debounce time, then a release tail of
    // up to the longer pedal grace (capped at 40) plus 3 items; the rest is bouncing noise
    task automatic run_phase(input int n_items);
        int         sent;
        int         hold;
        int         tail;
        int         deb;
        int         gmax;
        t_tick      lv;
        logic [2:0] btn;
        sent = 0;
        deb = sb.debounce;
        gmax = (sb.grace[PEDAL_CLUTCH] > sb.grace[PEDAL_BRAKE]) ?
               sb.grace[PEDAL_CLUTCH] : sb.grace[PEDAL_BRAKE];
        if (gmax > 40)
            gmax = 40;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                btn = 3'b001 << $urandom_range(0, 2);
                if ($urandom_range(0, 4) == 0)
                    btn = 3'($urandom_range(1, 7));
                hold = $urandom_range(0, 1) ? deb + 1 + $urandom_range(0, 4)
                                            : $urandom_range(1, deb + 4);
                lv.clutch = 1'($urandom_range(0, 1));
                lv.brake = 1'($urandom_range(0, 1));
                lv.onoff = ~btn[BTN_ONOFF];
                lv.down = ~btn[BTN_DOWN];
                lv.up = ~btn[BTN_UP];
                for (int k = 0; k < hold; k++) begin
                    if ($urandom_range(0, 15) == 0)
                        lv.clutch = ~lv.clutch;
                    send_tick(lv);
                    sent++;
                end
                tail = $urandom_range(1, gmax + 3);
                for (int k = 0; k < tail; k++) begin
                    send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
                    sent++;
                end
            end else begin
                hold = $urandom_range(1, 8);
                for (int k = 0; k < hold; k++) begin
                    send_tick(t_tick'($urandom_range(0, 31)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        sb = new();
        ticks_sent = 0;
        settings_run = 0;
        tx_burst = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_NO_PEDAL;
        i_cfg_data <= '0;
        tick_ch.valid <= 1'b0;
        tick_ch.clutch_level <= 1'b0;
        tick_ch.brake_level <= 1'b0;
        tick_ch.onoff_level <= 1'b1;
        tick_ch.down_level <= 1'b1;
        tick_ch.up_level <= 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: long grace keeps pedals reported, short press ignored
        send_levels(1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_levels(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);

        drain();
        cfg_write(CFG_DEBOUNCE, '0);
        cfg_write(CFG_CLUTCH_GRACE, 16'd1);
        cfg_write(CFG_BRAKE_GRACE, 16'd2);
        cfg_write(CFG_DEF_SPEED, '0);
        i_cfg_we <= 1'b0;
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        drain();
        cfg_write(CFG_DEF_SPEED, 16'd255);
        i_cfg_we <= 1'b0;
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        drain();
        // off-grid default: steps down once below the floor, then cannot step down further
        cfg_write(CFG_DEF_SPEED, 16'd33);
        i_cfg_we <= 1'b0;
        send_levels(1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_levels(1'b0, 1'b0, 1'b1, 1'b0, 1'b1);
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        // turn on, then all three at once: off first, down before up
        send_levels(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_levels(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_levels(1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
        send_levels(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_levels(1'b0, 1'b0, 1'b1, 1'b1, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            drain();
            set_phase_regs(p);
            run_phase(phase_items[p]);
        end
        drain();

        $display("Sent %0d tick items across %0d register settings, %0d results compared.",
                 ticks_sent, settings_run, sb.compared);
        $display("Predicted %0d turn-ons and %0d set speed steps.",
                 sb.turn_ons, sb.speed_steps);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
